/* src/bpc_pkg.sv */
// Shared types, register codes and constants for the barometric compensation core.
package bpc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int DIV_W      = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CAL_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_B  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OSS    = 3'd4;

	localparam logic [31:0] B6_OFFSET  = 32'd4000;
	localparam logic [31:0] P_MUL_SQ   = 32'd3038;
	localparam logic [31:0] P_MUL_LIN  = 32'hFFFF_E343; // -7357
	localparam logic [31:0] P_OFFSET   = 32'd3791;
	localparam logic [31:0] B7_SCALE   = 32'd50000;
	localparam logic [31:0] B4_BIAS    = 32'd32768;

	typedef struct packed {
		logic [31:0] ac1;
		logic [31:0] ac2;
		logic [31:0] ac3;
		logic [31:0] ac4;
		logic [31:0] ac5;
		logic [31:0] ac6;
		logic [31:0] b1;
		logic [31:0] b2;
		logic [31:0] mc;
		logic [31:0] md;
		logic [1:0]  oss;
	} bpc_cal_t;

endpackage

/* src/bpc_cfg.sv */
// Calibration register file with unpacked coefficients; ac4..ac6 are zero-extended, the rest sign-extended.
module bpc_cfg
	import bpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output bpc_cal_t              cal
);

	logic [47:0] cal_a_q;
	logic [47:0] cal_b_q;
	logic [31:0] curve_q;
	logic [31:0] temp_q;
	logic [1:0]  oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			curve_q <= '0;
			temp_q  <= '0;
			oss_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAL_A: cal_a_q <= cfg_data[47:0];
				REG_CAL_B: cal_b_q <= cfg_data[47:0];
				REG_CURVE: curve_q <= cfg_data[31:0];
				REG_TEMP:  temp_q  <= cfg_data[31:0];
				REG_OSS:   oss_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cal.ac1 = {{16{cal_a_q[47]}}, cal_a_q[47:32]};
		cal.ac2 = {{16{cal_a_q[31]}}, cal_a_q[31:16]};
		cal.ac3 = {{16{cal_a_q[15]}}, cal_a_q[15:0]};
		cal.ac4 = {16'd0, cal_b_q[47:32]};
		cal.ac5 = {16'd0, cal_b_q[31:16]};
		cal.ac6 = {16'd0, cal_b_q[15:0]};
		cal.b1  = {{16{curve_q[31]}}, curve_q[31:16]};
		cal.b2  = {{16{curve_q[15]}}, curve_q[15:0]};
		cal.mc  = {{16{temp_q[31]}}, temp_q[31:16]};
		cal.md  = {{16{temp_q[15]}}, temp_q[15:0]};
		cal.oss = oss_q;
	end

endmodule

/* src/bpc_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage, with side data.
module bpc_div
	import bpc_pkg::*;
#(
	parameter int W      = DIV_W,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [W-1:0]      num,
	input  logic [W-1:0]      den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [W-1:0]      quot,
	output logic [SIDE_W-1:0] side_out
);

	logic [W-1:0]      rem_s  [W];
	logic [W-1:0]      num_s  [W];
	logic [W-1:0]      den_s  [W];
	logic [SIDE_W-1:0] side_s [W];
	logic              vld_s  [W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W-1:0]      r_in, n_in, d_in;
		logic [SIDE_W-1:0] s_in;
		logic              v_in;
		logic [W:0]        t, diff;

		if (k == 0) begin : g_first
			assign r_in = '0;
			assign n_in = num;
			assign d_in = den;
			assign s_in = side_in;
			assign v_in = in_valid;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign n_in = num_s[k-1];
			assign d_in = den_s[k-1];
			assign s_in = side_s[k-1];
			assign v_in = vld_s[k-1];
		end

		assign t    = {r_in, n_in[W-1]};
		assign diff = t - {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= diff[W] ? t[W-1:0] : diff[W-1:0];
				num_s[k]  <= {n_in[W-2:0], ~diff[W]};
				den_s[k]  <= d_in;
				side_s[k] <= s_in;
			end
		end
	end

	assign out_valid = vld_s[W-1];
	assign quot      = num_s[W-1];
	assign side_out  = side_s[W-1];

endmodule

/* src/barometric_pressure_compensation_core.sv */
// Top level: pipelined barometer integer temperature and pressure compensation.
//
// Usage:
//   Calibration and oversampling are written through cfg_we / cfg_index /
//   cfg_data while no transaction is in flight. Index 0..4 selects the
//   coefficient group A, group B, b1/b2, mc/md and the oversampling setting.
//   A transaction on the input channel (in_valid high, in_stall low) carries
//   one temp_raw / pressure_raw pair. The output channel presents one result
//   per input with out_valid; it is taken when out_stall is low.
// Timing:
//   One pair per cycle sustained while the output is not stalled. The pipe
//   length is set by the two 32-stage bit-per-stage dividers (temperature
//   and pressure) plus the multiplier stages around them.
// Reset:
//   arst_n clears all calibration registers to zero and empties the pipe.
// Stall:
//   While out_valid is high and out_stall is high the whole pipe holds and
//   in_stall is raised; no transaction is lost or repeated.
module barometric_pressure_compensation_core
	import bpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [15:0]           temp_raw,
	input  logic [23:0]           pressure_raw,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [27:0]    temp_tenths,
	output logic signed [31:0]    pressure_pa,
	output logic                  temp_div_fault,
	output logic                  press_div_fault
);

	localparam int SIDE_A_W = 24 + 32 + 2;
	localparam int SIDE_B_W = 32 + 3;

	bpc_cal_t cal;
	logic     en;

	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cal       (cal)
	);

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// temperature front end
	logic        v_s1, v_s2, v_s3, v_s4;
	logic [23:0] up_s1, up_s2, up_s3, up_s4;
	logic [31:0] t0_s1, prod_s2, x1_s3, dv_s3, x1_s4;
	logic [31:0] num_a_s4, den_a_s4;
	logic        tflag_s4, neg_s4;
	logic [31:0] x1_c, nm_c;

	assign x1_c = 32'($signed(prod_s2) >>> 15);
	assign nm_c = cal.mc << 11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			up_s1    <= pressure_raw >> (4'd8 - {2'b00, cal.oss});
			t0_s1    <= {16'd0, temp_raw} - cal.ac6;
			up_s2    <= up_s1;
			prod_s2  <= t0_s1 * cal.ac5;
			up_s3    <= up_s2;
			x1_s3    <= x1_c;
			dv_s3    <= x1_c + cal.md;
			up_s4    <= up_s3;
			x1_s4    <= x1_s3;
			tflag_s4 <= (dv_s3 == '0);
			neg_s4   <= nm_c[31] ^ dv_s3[31];
			num_a_s4 <= nm_c[31] ? (32'd0 - nm_c) : nm_c;
			den_a_s4 <= (dv_s3 == '0) ? 32'd1 : (dv_s3[31] ? (32'd0 - dv_s3) : dv_s3);
		end
	end

	logic                va_o;
	logic [31:0]         qa_o;
	logic [SIDE_A_W-1:0] sa_o;

	bpc_div #(.W(DIV_W), .SIDE_W(SIDE_A_W)) u_div_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num       (num_a_s4),
		.den       (den_a_s4),
		.side_in   ({up_s4, x1_s4, tflag_s4, neg_s4}),
		.out_valid (va_o),
		.quot      (qa_o),
		.side_out  (sa_o)
	);

	// pressure chain
	logic        v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14;
	logic [31:0] b5_s5, b5_s6, b5_s7, b5_s8, b5_s9, b5_s10, b5_s11, b5_s12, b5_s13, b5_s14;
	logic        tf_s5, tf_s6, tf_s7, tf_s8, tf_s9, tf_s10, tf_s11, tf_s12, tf_s13, tf_s14;
	logic [23:0] up_s5, up_s6, up_s7, up_s8, up_s9, up_s10, up_s11;
	logic [31:0] b6_s6, sqp_s7, a2p_s7, a3p_s7, sq_s8, x2a_s8, x1c_s8;
	logic [31:0] x2a_s9, x1c_s9, b2sq_s9, b1sq_s9;
	logic [31:0] b3n_s10, x3b_s10, b3_s11, x3c_s11;
	logic [31:0] b4_s12, t_s12, b4_s13, b7_s13;
	logic        pf_s13, pf_s14, mode_s14;
	logic [31:0] num_b_s14, den_b_s14;
	logic [31:0] qa_sgn, x3_c, b3b_c, x3b_c;

	assign qa_sgn = sa_o[0] ? (32'd0 - qa_o) : qa_o;
	assign x3_c   = 32'($signed(b2sq_s9) >>> 11) + x2a_s9;
	assign b3b_c  = ((cal.ac1 << 2) + x3_c) << cal.oss;
	assign x3b_c  = x1c_s9 + 32'($signed(b1sq_s9) >>> 16) + 32'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else if (en) begin
			v_s5  <= va_o;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b5_s5   <= sa_o[1] ? 32'd0 : (sa_o[33:2] + qa_sgn);
			tf_s5   <= sa_o[1];
			up_s5   <= sa_o[57:34];

			b5_s6   <= b5_s5;
			tf_s6   <= tf_s5;
			up_s6   <= up_s5;
			b6_s6   <= b5_s5 - B6_OFFSET;

			b5_s7   <= b5_s6;
			tf_s7   <= tf_s6;
			up_s7   <= up_s6;
			sqp_s7  <= b6_s6 * b6_s6;
			a2p_s7  <= cal.ac2 * b6_s6;
			a3p_s7  <= cal.ac3 * b6_s6;

			b5_s8   <= b5_s7;
			tf_s8   <= tf_s7;
			up_s8   <= up_s7;
			sq_s8   <= 32'($signed(sqp_s7) >>> 12);
			x2a_s8  <= 32'($signed(a2p_s7) >>> 11);
			x1c_s8  <= 32'($signed(a3p_s7) >>> 13);

			b5_s9   <= b5_s8;
			tf_s9   <= tf_s8;
			up_s9   <= up_s8;
			x2a_s9  <= x2a_s8;
			x1c_s9  <= x1c_s8;
			b2sq_s9 <= cal.b2 * sq_s8;
			b1sq_s9 <= cal.b1 * sq_s8;

			b5_s10  <= b5_s9;
			tf_s10  <= tf_s9;
			up_s10  <= up_s9;
			b3n_s10 <= b3b_c + 32'd2;
			x3b_s10 <= 32'($signed(x3b_c) >>> 2);

			b5_s11  <= b5_s10;
			tf_s11  <= tf_s10;
			up_s11  <= up_s10;
			b3_s11  <= 32'($signed(b3n_s10 + (b3n_s10[31] ? 32'd3 : 32'd0)) >>> 2);
			x3c_s11 <= x3b_s10 + B4_BIAS;

			b5_s12  <= b5_s11;
			tf_s12  <= tf_s11;
			b4_s12  <= (cal.ac4 * x3c_s11) >> 15;
			t_s12   <= {8'd0, up_s11} - b3_s11;

			b5_s13  <= b5_s12;
			tf_s13  <= tf_s12;
			b4_s13  <= b4_s12;
			pf_s13  <= (b4_s12 == '0);
			b7_s13  <= t_s12 * (B7_SCALE >> cal.oss);

			b5_s14    <= b5_s13;
			tf_s14    <= tf_s13;
			pf_s14    <= pf_s13;
			mode_s14  <= b7_s13[31];
			num_b_s14 <= b7_s13[31] ? b7_s13 : (b7_s13 << 1);
			den_b_s14 <= pf_s13 ? 32'd1 : b4_s13;
		end
	end

	logic                vb_o;
	logic [31:0]         qb_o;
	logic [SIDE_B_W-1:0] sb_o;

	bpc_div #(.W(DIV_W), .SIDE_W(SIDE_B_W)) u_div_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s14),
		.num       (num_b_s14),
		.den       (den_b_s14),
		.side_in   ({b5_s14, tf_s14, pf_s14, mode_s14}),
		.out_valid (vb_o),
		.quot      (qb_o),
		.side_out  (sb_o)
	);

	// final pressure correction
	logic        v_s15, v_s16, v_s17, v_s18;
	logic [31:0] b5_s15, b5_s16, b5_s17, b5_s18;
	logic        tf_s15, tf_s16, tf_s17, tf_s18;
	logic        pf_s15, pf_s16, pf_s17, pf_s18;
	logic [31:0] p_s15, p_s16, p_s17, p_s18;
	logic [31:0] sqp_s16, x2p_s16, m3_s17, x2_s17, sum_s18;
	logic [31:0] p8_c, t8_c;

	assign p8_c = 32'($signed(p_s15) >>> 8);
	assign t8_c = b5_s18 + 32'd8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s15     <= 1'b0;
			v_s16     <= 1'b0;
			v_s17     <= 1'b0;
			v_s18     <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s15     <= vb_o;
			v_s16     <= v_s15;
			v_s17     <= v_s16;
			v_s18     <= v_s17;
			out_valid <= v_s18;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b5_s15  <= sb_o[34:3];
			tf_s15  <= sb_o[2];
			pf_s15  <= sb_o[1];
			p_s15   <= sb_o[0] ? (qb_o << 1) : qb_o;

			b5_s16  <= b5_s15;
			tf_s16  <= tf_s15;
			pf_s16  <= pf_s15;
			p_s16   <= p_s15;
			sqp_s16 <= p8_c * p8_c;
			x2p_s16 <= P_MUL_LIN * p_s15;

			b5_s17  <= b5_s16;
			tf_s17  <= tf_s16;
			pf_s17  <= pf_s16;
			p_s17   <= p_s16;
			m3_s17  <= sqp_s16 * P_MUL_SQ;
			x2_s17  <= 32'($signed(x2p_s16) >>> 16);

			b5_s18  <= b5_s17;
			tf_s18  <= tf_s17;
			pf_s18  <= pf_s17;
			p_s18   <= p_s17;
			sum_s18 <= 32'($signed(m3_s17) >>> 16) + x2_s17 + P_OFFSET;

			temp_tenths     <= t8_c[31:4];
			pressure_pa     <= pf_s18 ? 32'sd0 : (p_s18 + 32'($signed(sum_s18) >>> 4));
			temp_div_fault  <= tf_s18;
			press_div_fault <= pf_s18;
		end
	end

endmodule

/* src/bpc_checker.sv */
// Port-level checker for the compensation core, bound to the top level.
module bpc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [27:0] temp_tenths,
	input logic signed [31:0] pressure_pa,
	input logic               temp_div_fault,
	input logic               press_div_fault
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pressure_pa) && $stable(temp_tenths))
		else $error("stalled result changed");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	a_press_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && press_div_fault |-> pressure_pa == 32'sd0)
		else $error("pressure not zero on divisor fault");

	a_temp_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && temp_div_fault |-> temp_tenths == 28'sd0)
		else $error("temperature not zero on divisor fault");

endmodule

bind barometric_pressure_compensation_core bpc_checker u_bpc_checker (.*);
